// ----- rtl/core/rsa_pkg.sv -----
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and codes for the ring suballocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

   localparam int OFF_W = 25;
   localparam int TAG_W = 8;
   localparam int AL_W  = 13;
   // working width of positions: end of an entry plus alignment padding
   localparam int POS_W = 27;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_DONE  = 2'd2,
      MODE_RSVD  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BUSY     = 3'd1,
      ST_BAD      = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   localparam logic KIND_NOTICE = 1'b0;
   localparam logic KIND_FINAL  = 1'b1;

   typedef struct packed {
      logic [1:0]       mode;
      logic [TAG_W-1:0] tag;
      logic [OFF_W-1:0] req_size;
      logic [AL_W-1:0]  alignment;
   } req_type;

   typedef struct packed {
      logic             kind;
      logic [2:0]       status;
      logic [OFF_W-1:0] offset;
      logic [TAG_W-1:0] out_tag;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [OFF_W-1:0] off;
      logic [OFF_W-1:0] len;
      logic [TAG_W-1:0] id;
      logic             fin;
   } entry_type;

   typedef enum logic [2:0] {
      OP_NOP  = 3'd0,
      OP_INS  = 3'd1,
      OP_REM  = 3'd2,
      OP_LOAD = 3'd3,
      OP_SETF = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   ent;
   } cell_ctl_type;

endpackage

// ----- rtl/core/rsa_cell.sv -----
// ----------------------------------------------------------------------------
// rsa_cell
// One table slot: holds an entry, shifts with its neighbors on insert/remove.
// ----------------------------------------------------------------------------
module rsa_cell import rsa_pkg::*; #(
   parameter int IW = 4
) (
   input  logic         clock,
   input  logic [IW-1:0] my_idx,
   input  logic [IW-1:0] op_idx,
   input  cell_ctl_type ctl,
   input  entry_type    left_ent,
   input  entry_type    right_ent,
   output entry_type    ent
);

   entry_type ent_ff, ent_in;

   // next entry from the shared command
   always_comb begin
      ent_in = ent_ff;
      case (ctl.op)
         OP_INS: begin
            if (my_idx > op_idx) ent_in = left_ent;
            else if (my_idx == op_idx) ent_in = ctl.ent;
         end
         OP_REM: begin
            if (my_idx >= op_idx) ent_in = right_ent;
         end
         OP_LOAD: begin
            if (my_idx == op_idx) ent_in = ctl.ent;
         end
         OP_SETF: begin
            if (my_idx == op_idx) ent_in.fin = 1'b1;
         end
         default: ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent = ent_ff;

endmodule

// ----- rtl/core/rsa_align.sv -----
// ----------------------------------------------------------------------------
// rsa_align
// Rounds a position up to a multiple of an arbitrary alignment, one
// remainder bit per cycle.
// ----------------------------------------------------------------------------
module rsa_align import rsa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [POS_W-1:0] value,
   input  logic [AL_W-1:0]  align,
   output logic             busy,
   output logic             done,
   output logic [POS_W-1:0] result
);

   localparam int CNT_W = $clog2(POS_W + 1);

   logic [POS_W-1:0] val_ff, val_in, sh_ff, sh_in;
   logic [AL_W-1:0]  al_ff, al_in;
   logic [AL_W:0]    rem_ff, rem_in, trial;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;

   // restoring remainder step
   always_comb begin
      val_in  = val_ff;
      sh_in   = sh_ff;
      al_in   = al_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[AL_W-1:0], sh_ff[POS_W-1]};
      if (start) begin
         val_in = value;
         sh_in  = value;
         al_in  = align;
         rem_in = '0;
         cnt_in = CNT_W'(POS_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         sh_in  = {sh_ff[POS_W-2:0], 1'b0};
         rem_in = (trial >= {1'b0, al_ff}) ? trial - {1'b0, al_ff} : trial;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff <= val_in;
      sh_ff  <= sh_in;
      al_ff  <= al_in;
      rem_ff <= rem_in;
   end

   assign busy   = run_ff;
   assign done   = done_ff;
   assign result = (rem_ff == '0) ? val_ff
                 : val_ff + POS_W'({1'b0, al_ff} - rem_ff);

endmodule

// ----- rtl/core/ring_suballocator_with_reclaim.sv -----
// ----------------------------------------------------------------------------
// ring_suballocator_with_reclaim
// Offset-ordered first-fit suballocator with reclaim of done entries.
// ----------------------------------------------------------------------------
// Entries live in a chain of cells that shift together on insert and remove.
// Free and mark done scan the table one entry per cycle. An allocate first
// tries the space after the last entry, aligned by the bit-serial alignment
// unit; a full walk adds one alignment for each live entry passed and
// reclaims each done entry it meets. Results appear one cycle each on
// rsp_valid and must be taken when shown; the final result of a transaction
// has last set and busy drops with it.
module ring_suballocator_with_reclaim import rsa_pkg::*; #(
   parameter int MAX_ENTRIES = 16,
   parameter int MAX_ALIGN   = 4096,
   parameter int SIZE_BITS   = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_item,
   output logic             rsp_valid,
   output rsp_type          rsp_item,
   input  logic             csr_we,
   input  logic [OFF_W-1:0] csr_wdata
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [32:0] SIZE_LIM  = 33'(1) << SIZE_BITS;
   localparam logic [16:0] ALIGN_LIM = 17'(MAX_ALIGN);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FIND  = 7'b0000010,
      S_ALT   = 7'b0000100,
      S_TCHK  = 7'b0001000,
      S_WALK  = 7'b0010000,
      S_ALW   = 7'b0100000,
      S_FIN   = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [OFF_W-1:0] pool_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic [IW-1:0]    ptr_ff, ptr_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rv_ff, rv_in;
   rsp_type          rsp_ff, rsp_in;

   cell_ctl_type     ctl;
   logic [IW-1:0]    op_idx;
   entry_type        cells [MAX_ENTRIES];
   entry_type        rd;
   logic [POS_W-1:0] rd_off, rd_end, pool_w;
   logic             al_start, al_busy, al_done;
   logic [POS_W-1:0] al_val, al_res;
   logic             bad;

   // chain of table cells
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      entry_type lft, rgt;
      if (g == 0) begin : g_l0
         assign lft = cells[g];
      end else begin : g_l
         assign lft = cells[g-1];
      end
      if (g == MAX_ENTRIES-1) begin : g_rn
         assign rgt = cells[g];
      end else begin : g_r
         assign rgt = cells[g+1];
      end
      rsa_cell #(.IW(IW)) u_cell (
         .clock     (clock),
         .my_idx    (IW'(g)),
         .op_idx    (op_idx),
         .ctl       (ctl),
         .left_ent  (lft),
         .right_ent (rgt),
         .ent       (cells[g])
      );
   end

   rsa_align u_align (
      .clock  (clock),
      .reset  (reset),
      .start  (al_start),
      .value  (al_val),
      .align  (req_ff.alignment),
      .busy   (al_busy),
      .done   (al_done),
      .result (al_res)
   );

   // entry under the scan pointer
   assign rd     = cells[ptr_ff];
   assign rd_off = POS_W'(rd.off);
   assign rd_end = POS_W'(rd.off) + POS_W'(rd.len);
   assign pool_w = POS_W'(pool_ff);
   assign al_val = rd_end;

   assign bad = (req_item.alignment == '0) || ({4'b0, req_item.alignment} > ALIGN_LIM)
              || (req_item.req_size > pool_ff) || (33'(req_item.req_size) > SIZE_LIM);

   // sequencer
   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      pos_in   = pos_ff;
      rv_in    = 1'b0;
      rsp_in   = rsp_ff;
      ctl.op   = OP_NOP;
      ctl.ent  = '{off: pos_ff[OFF_W-1:0], len: req_ff.req_size, id: req_ff.tag,
                   fin: 1'b0};
      op_idx   = ptr_ff;
      al_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               rv_in  = 1'b1;
               rsp_in = '{kind: KIND_FINAL, status: ST_OK, offset: '0,
                          out_tag: req_item.tag, last: 1'b1};
               case (req_item.mode)
                  MODE_FREE, MODE_DONE: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_NOTFOUND;
                     end else begin
                        rv_in    = 1'b0;
                        ptr_in   = '0;
                        state_in = S_FIND;
                     end
                  end
                  MODE_ALLOC: begin
                     if (bad) begin
                        rsp_in.status = ST_BAD;
                     end else if (count_ff >= CW'(MAX_ENTRIES)) begin
                        rsp_in.status = ST_FULL;
                     end else if (count_ff == '0) begin
                        ctl.op  = OP_INS;
                        ctl.ent = '{off: '0, len: req_item.req_size, id: req_item.tag,
                                    fin: 1'b0};
                        op_idx   = '0;
                        count_in = count_ff + 1'b1;
                     end else begin
                        rv_in    = 1'b0;
                        ptr_in   = IW'(count_ff - 1'b1);
                        state_in = S_ALT;
                     end
                  end
                  default: rsp_in.status = ST_BAD;
               endcase
            end
         end
         S_FIND: begin
            if (rd.id == req_ff.tag) begin
               if (req_ff.mode == MODE_FREE) begin
                  ctl.op   = OP_REM;
                  count_in = count_ff - 1'b1;
               end else begin
                  ctl.op = OP_SETF;
               end
               rv_in    = 1'b1;
               rsp_in   = '{kind: KIND_FINAL, status: ST_OK, offset: '0,
                            out_tag: req_ff.tag, last: 1'b1};
               state_in = S_IDLE;
            end else if (CW'(ptr_ff) == count_ff - 1'b1) begin
               rv_in    = 1'b1;
               rsp_in   = '{kind: KIND_FINAL, status: ST_NOTFOUND, offset: '0,
                            out_tag: req_ff.tag, last: 1'b1};
               state_in = S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_ALT: begin
            // align the end of the last entry
            if (!al_busy && !al_done) al_start = 1'b1;
            if (al_done) begin
               pos_in   = al_res;
               state_in = S_TCHK;
            end
         end
         S_TCHK: begin
            if (pool_w >= pos_ff && (pool_w - pos_ff) >= POS_W'(req_ff.req_size)) begin
               ctl.op   = OP_INS;
               op_idx   = IW'(count_ff);
               count_in = count_ff + 1'b1;
               rv_in    = 1'b1;
               rsp_in   = '{kind: KIND_FINAL, status: ST_OK, offset: pos_ff[OFF_W-1:0],
                            out_tag: req_ff.tag, last: 1'b1};
               state_in = S_IDLE;
            end else begin
               pos_in   = '0;
               ptr_in   = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (CW'(ptr_ff) == count_ff) begin
               rv_in    = 1'b1;
               rsp_in   = '{kind: KIND_FINAL, status: ST_BUSY, offset: '0,
                            out_tag: req_ff.tag, last: 1'b1};
               state_in = S_IDLE;
            end else if (rd_off >= pos_ff && (rd_off - pos_ff) >= POS_W'(req_ff.req_size)) begin
               ctl.op   = OP_INS;
               count_in = count_ff + 1'b1;
               rv_in    = 1'b1;
               rsp_in   = '{kind: KIND_FINAL, status: ST_OK, offset: pos_ff[OFF_W-1:0],
                            out_tag: req_ff.tag, last: 1'b1};
               state_in = S_IDLE;
            end else if (rd.fin) begin
               // reclaim notice; refill in place if the freed span fits
               rv_in  = 1'b1;
               rsp_in = '{kind: KIND_NOTICE, status: ST_OK, offset: rd.off,
                          out_tag: rd.id, last: 1'b0};
               if (rd_end >= pos_ff && (rd_end - pos_ff) >= POS_W'(req_ff.req_size)) begin
                  ctl.op   = OP_LOAD;
                  state_in = S_FIN;
               end else begin
                  ctl.op   = OP_REM;
                  count_in = count_ff - 1'b1;
               end
            end else begin
               al_start = 1'b1;
               state_in = S_ALW;
            end
         end
         S_ALW: begin
            if (al_done) begin
               pos_in   = al_res;
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_WALK;
            end
         end
         S_FIN: begin
            rv_in    = 1'b1;
            rsp_in   = '{kind: KIND_FINAL, status: ST_OK, offset: pos_ff[OFF_W-1:0],
                         out_tag: req_ff.tag, last: 1'b1};
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
         pool_ff  <= OFF_W'(65536);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
         if (csr_we) pool_ff <= csr_wdata;
      end
      req_ff <= req_in;
      ptr_ff <= ptr_in;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_item  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count above table depth");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_ff.last |-> state_ff == S_IDLE)
      else $error("final result while still busy");
   a_notice_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_ff.kind == KIND_NOTICE |-> busy)
      else $error("reclaim notice outside a walk");
   a_align_start: assert property (@(posedge clock) disable iff (reset)
      al_start |-> !al_busy)
      else $error("alignment unit restarted while running");
`endif

endmodule

// ----- tb/tb_ring_suballocator_with_reclaim.sv -----
// ----------------------------------------------------------------------------
// tb_ring_suballocator_with_reclaim
// Self-checking bench for the first-fit suballocator with reclaim: a directed
// table, then random allocate/free/done traffic with a few pool sizes, every
// result checked against a behavioral model of the entry table.
// ----------------------------------------------------------------------------
module tb_ring_suballocator_with_reclaim;
   timeunit 1ns;
   timeprecision 1ps;
   import rsa_pkg::*;

   localparam int NENT    = 16;
   localparam int ALIGN_MAX = 4096;
   localparam longint SIZE_CAP = 64'd1 << 24;
   localparam int WD_LIMIT = 20000;

   logic clock, reset, start, busy, rsp_valid, csr_we;
   req_type req_item;
   rsp_type rsp_item;
   logic [OFF_W-1:0] csr_wdata;

   ring_suballocator_with_reclaim uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // model state
   longint pool_bytes;
   longint tbl_off[$], tbl_len[$];
   int     tbl_tag[$];
   bit     tbl_fin[$];
   rsp_type pending_rsp[$];
   int  fails;
   int  idle_cycles;
   bit  quiet;

   function automatic longint round_up(longint v, longint a);
      longint w;
      w = v % a;
      return (w != 0) ? v + (a - w) : v;
   endfunction

   function automatic void queue_rsp(logic k, status_type st, longint off, int tg,
                                     logic lst);
      rsp_type r;
      r.kind = k; r.status = st; r.offset = off[OFF_W-1:0];
      r.out_tag = tg[TAG_W-1:0]; r.last = lst;
      pending_rsp.push_back(r);
   endfunction

   function automatic void put_entry(int i, longint off, longint len, int tg);
      tbl_off.insert(i, off & 64'h1FFFFFF); tbl_len.insert(i, len);
      tbl_tag.insert(i, tg); tbl_fin.insert(i, 1'b0);
   endfunction

   function automatic void drop_entry(int i);
      tbl_off.delete(i); tbl_len.delete(i); tbl_tag.delete(i); tbl_fin.delete(i);
   endfunction

   // expected results of one accepted transaction
   function automatic void predict_alloc(req_type rq);
      int f, i;
      longint sz, al, pos, o, e;
      f = -1;
      if (rq.mode == MODE_FREE || rq.mode == MODE_DONE) begin
         foreach (tbl_tag[k]) if (f < 0 && tbl_tag[k] == rq.tag) f = k;
         if (f < 0) begin
            queue_rsp(KIND_FINAL, ST_NOTFOUND, 0, rq.tag, 1'b1);
            return;
         end
         if (rq.mode == MODE_FREE) drop_entry(f);
         else tbl_fin[f] = 1'b1;
         queue_rsp(KIND_FINAL, ST_OK, 0, rq.tag, 1'b1);
         return;
      end
      if (rq.mode == MODE_RSVD) begin
         queue_rsp(KIND_FINAL, ST_BAD, 0, rq.tag, 1'b1);
         return;
      end
      sz = rq.req_size; al = rq.alignment;
      if (al == 0 || al > ALIGN_MAX || sz > pool_bytes || sz > SIZE_CAP) begin
         queue_rsp(KIND_FINAL, ST_BAD, 0, rq.tag, 1'b1);
         return;
      end
      if (tbl_off.size() >= NENT) begin
         queue_rsp(KIND_FINAL, ST_FULL, 0, rq.tag, 1'b1);
         return;
      end
      if (tbl_off.size() == 0) begin
         put_entry(0, 0, sz, rq.tag);
         queue_rsp(KIND_FINAL, ST_OK, 0, rq.tag, 1'b1);
         return;
      end
      // room after the last entry
      pos = round_up(tbl_off[$] + tbl_len[$], al);
      if (pool_bytes >= pos && pool_bytes - pos >= sz) begin
         put_entry(tbl_off.size(), pos, sz, rq.tag);
         queue_rsp(KIND_FINAL, ST_OK, pos, rq.tag, 1'b1);
         return;
      end
      // first-fit walk with reclaim of done entries
      pos = 0; i = 0;
      while (i < tbl_off.size()) begin
         o = tbl_off[i]; e = o + tbl_len[i];
         if (o >= pos && o - pos >= sz) begin
            put_entry(i, pos, sz, rq.tag);
            queue_rsp(KIND_FINAL, ST_OK, pos, rq.tag, 1'b1);
            return;
         end
         if (tbl_fin[i]) begin
            queue_rsp(KIND_NOTICE, ST_OK, o, tbl_tag[i], 1'b0);
            drop_entry(i);
            if (e >= pos && e - pos >= sz) begin
               put_entry(i, pos, sz, rq.tag);
               queue_rsp(KIND_FINAL, ST_OK, pos, rq.tag, 1'b1);
               return;
            end
         end else begin
            pos = round_up(e, al);
            i++;
         end
      end
      queue_rsp(KIND_FINAL, ST_BUSY, 0, rq.tag, 1'b1);
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h",
                        $time, rsp_item);
               fails++;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_item !== exp_rsp) begin
                  $display("%0t: mismatch expected k%0d s%0d off %0d tag %0d l%0d",
                           $time, exp_rsp.kind, exp_rsp.status, exp_rsp.offset,
                           exp_rsp.out_tag, exp_rsp.last);
                  $display("%0t:          actual   k%0d s%0d off %0d tag %0d l%0d",
                           $time, rsp_item.kind, rsp_item.status, rsp_item.offset,
                           rsp_item.out_tag, rsp_item.last);
                  fails++;
               end
            end
         end
         if (rsp_valid || (start && !busy) || csr_we) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WD_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // one transaction: drive at a falling edge, hold start until the accepting
   // edge; start stays high for a following transaction with no gap
   task automatic send_req(req_type rq);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 14);
         repeat (gap) @(negedge clock);
      end
      req_item <= rq;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_alloc(rq);
   endtask

   task automatic drain_rsp();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_pool(longint v);
      drain_rsp();
      csr_wdata <= v[OFF_W-1:0];
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      pool_bytes = v;
   endtask

   function automatic req_type mk_req(mode_type m, int tg, longint sz, int al);
      req_type r;
      r.mode = m; r.tag = tg[TAG_W-1:0]; r.req_size = sz[OFF_W-1:0];
      r.alignment = al[AL_W-1:0];
      return r;
   endfunction

   // directed table; a status of 7 means check against the model only
   typedef struct {
      mode_type m; int tg; longint sz; int al; int exp_st;
   } dir_row_type;

   dir_row_type dir_rows[] = '{
      '{MODE_FREE,  8'h00, 0, 1, ST_NOTFOUND},
      '{MODE_DONE,  8'hFF, 0, 1, ST_NOTFOUND},
      '{MODE_RSVD,  8'hA5, 25'h1FFFFFF, 13'h1FFF, ST_BAD},
      '{MODE_ALLOC, 1, 0, 0, ST_BAD},
      '{MODE_ALLOC, 2, 16, 4097, ST_BAD},
      '{MODE_ALLOC, 3, 65537, 1, ST_BAD},
      '{MODE_ALLOC, 4, 25'h1FFFFFF, 8191, ST_BAD},
      '{MODE_ALLOC, 10, 1000, 1, ST_OK},
      '{MODE_ALLOC, 11, 3000, 4096, 7},
      '{MODE_ALLOC, 12, 500, 16, 7},
      '{MODE_ALLOC, 11, 100, 1, 7},
      '{MODE_DONE,  10, 0, 1, ST_OK},
      '{MODE_DONE,  11, 0, 1, ST_OK},
      '{MODE_ALLOC, 13, 60000, 1, 7},
      '{MODE_ALLOC, 14, 65536, 1, 7},
      '{MODE_FREE,  12, 0, 1, 7},
      '{MODE_FREE,  11, 0, 1, 7},
      '{MODE_ALLOC, 15, 65536, 4096, 7},
      '{MODE_FREE,  15, 0, 1, 7},
      '{MODE_FREE,  14, 0, 1, 7},
      '{MODE_FREE,  13, 0, 1, 7}
   };

   int tags_live[$];

   function automatic req_type rand_req();
      int sel, al;
      longint sz;
      sel = $urandom_range(0, 99);
      al = 1 << $urandom_range(0, 12);
      if ($urandom_range(0, 15) == 0) al = $urandom_range(0, 8191);
      if ($urandom_range(0, 9) == 0) sz = $urandom_range(0, 33554431);
      else if ($urandom_range(0, 3) == 0) sz = $urandom_range(0, pool_bytes);
      else sz = $urandom_range(0, pool_bytes / 8 + 1);
      if (sel < 50) return mk_req(MODE_ALLOC, $urandom_range(0, 255), sz, al);
      if (sel < 72 && tbl_tag.size() > 0)
         return mk_req(MODE_DONE, tbl_tag[$urandom_range(0, tbl_tag.size() - 1)],
                       $urandom, $urandom);
      if (sel < 92 && tbl_tag.size() > 0)
         return mk_req(MODE_FREE, tbl_tag[$urandom_range(0, tbl_tag.size() - 1)],
                       $urandom, $urandom);
      return mk_req(mode_type'($urandom_range(1, 3)), $urandom_range(0, 255),
                    $urandom, $urandom);
   endfunction

   initial begin
      longint pools[5] = '{65536, 0, 16777216, 4096, 33554431};
      req_type rq;
      fails = 0; idle_cycles = 0; quiet = 0;
      reset = 1'b1; start = 1'b0; csr_we = 1'b0; csr_wdata = '0;
      req_item = '0; pool_bytes = 65536;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      foreach (dir_rows[k]) begin
         rq = mk_req(dir_rows[k].m, dir_rows[k].tg, dir_rows[k].sz, dir_rows[k].al);
         send_req(rq);
         if (dir_rows[k].exp_st != 7 && pending_rsp.size() > 0 &&
             pending_rsp[$].status != status_type'(dir_rows[k].exp_st)) begin
            $display("%0t: table row %0d expected status %0d, model %0d", $time, k,
                     dir_rows[k].exp_st, pending_rsp[$].status);
            fails++;
         end
      end

      // random phases over several pool sizes
      for (int ph = 0; ph < 6; ph++) begin
         write_pool(ph < 5 ? pools[ph] : 64'($urandom_range(1, 200000)));
         // clear the table to a known state for the new pool size
         while (tbl_tag.size() > 0) send_req(mk_req(MODE_FREE, tbl_tag[0], 0, 1));
         if (ph == 5) quiet = 1;
         for (int n = 0; n < 70; n++) begin
            send_req(rand_req());
            if (n == 35 && ph == 2) drain_rsp();
         end
      end

      drain_rsp();
      if (fails == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/rsa_pkg.sv
rtl/core/rsa_cell.sv
rtl/core/rsa_align.sv
rtl/core/ring_suballocator_with_reclaim.sv
tb/tb_ring_suballocator_with_reclaim.sv
